@@ rtl/gitr_pkg.sv @@
package gitr_pkg;

    localparam int SLOTS   = 32;
    localparam int ID_W    = 5;
    localparam int COORD_W = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_MOVE   = 2'd2;

    localparam logic [2:0] KIND_ENTER  = 3'd0;
    localparam logic [2:0] KIND_LEAVE  = 3'd1;
    localparam logic [2:0] KIND_MOVE   = 3'd2;
    localparam logic [2:0] KIND_INVIEW = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;

    localparam logic REG_GRID_SIZE   = 1'b0;
    localparam logic REG_VIEW_RADIUS = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } slot_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SCAN,
        S_WRITE,
        S_EMIT,
        S_INVIEW,
        S_STATUS
    } state_t;

    // cells within radius on one axis
    function automatic logic axis_near(logic signed [COORD_W-1:0] a,
                                       logic signed [COORD_W-1:0] b,
                                       logic [2:0] r);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] m;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            m = d[COORD_W] ? (~d + 1'b1) : d;
            axis_near = (m <= {{(COORD_W-2){1'b0}}, r});
        end
    endfunction

endpackage

@@ rtl/gitr_div.sv @@
module gitr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic [gitr_pkg::COORD_W-1:0]        divisor,
    input  logic signed [gitr_pkg::COORD_W-1:0] nx,
    input  logic signed [gitr_pkg::COORD_W-1:0] ny,
    output logic                               done,
    output logic signed [gitr_pkg::COORD_W-1:0] qx,
    output logic signed [gitr_pkg::COORD_W-1:0] qy
);
    import gitr_pkg::*;

    // restoring divide on magnitudes, x and y side by side, one bit per cycle
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COORD_W-1:0]      d_reg, d_next;
    logic [COORD_W-1:0]      ax_reg, ax_next, ay_reg, ay_next;
    logic [COORD_W:0]        rx_reg, rx_next, ry_reg, ry_next;
    logic                    sx_reg, sx_next, sy_reg, sy_next;
    logic [COORD_W:0]        tx, ty;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        tx = {rx_reg[COORD_W-1:0], ax_reg[COORD_W-1]};
        ty = {ry_reg[COORD_W-1:0], ay_reg[COORD_W-1]};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            d_next   = (divisor == '0) ? COORD_W'(1) : divisor;
            sx_next  = nx[COORD_W-1];
            sy_next  = ny[COORD_W-1];
            ax_next  = nx[COORD_W-1] ? (~nx + 1'b1) : nx;
            ay_next  = ny[COORD_W-1] ? (~ny + 1'b1) : ny;
            rx_next  = '0;
            ry_next  = '0;
        end
        else if (run_reg)
        begin
            if (tx >= {1'b0, d_reg})
            begin
                rx_next = tx - {1'b0, d_reg};
                ax_next = {ax_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                rx_next = tx;
                ax_next = {ax_reg[COORD_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, d_reg})
            begin
                ry_next = ty - {1'b0, d_reg};
                ay_next = {ay_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                ry_next = ty;
                ay_next = {ay_reg[COORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(COORD_W-1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
    end

    assign done = done_reg;
    assign qx   = sx_reg ? (~ax_reg + 1'b1) : ax_reg;
    assign qy   = sy_reg ? (~ay_reg + 1'b1) : ay_reg;

endmodule

@@ rtl/gitr_mem.sv @@
module gitr_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [gitr_pkg::ID_W-1:0]     waddr,
    input  gitr_pkg::slot_entry_t         wdata,
    input  logic                          re,
    input  logic [gitr_pkg::ID_W-1:0]     raddr,
    output gitr_pkg::slot_entry_t         rdata
);
    import gitr_pkg::*;

    slot_entry_t mem [SLOTS];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/grid_interest_tracker.sv @@
// Sequence: a status-only request goes from the check straight to the status strobe;
//   a full request runs check, divide, scan, write-back, three notice passes,
//   an in-view pass, and status.
// Throughput: one request at a time; busy stays high until the status item.
// Reset: asynchronous, active low; clears all slot valid bits and config
//   registers to grid_size 64, view_radius 1. Results cannot be stalled.
module grid_interest_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic [gitr_pkg::ID_W-1:0]           entity_id,
    input  logic signed [gitr_pkg::COORD_W-1:0] pos_x,
    input  logic signed [gitr_pkg::COORD_W-1:0] pos_y,
    input  logic                                wr_en,
    input  logic                                wr_index,
    input  logic [15:0]                         wr_data,
    output logic                                strobe,
    output logic [gitr_pkg::ID_W-1:0]           target_id,
    output logic [2:0]                          kind,
    output logic [gitr_pkg::ID_W-1:0]           about_id,
    output logic signed [gitr_pkg::COORD_W-1:0] about_x,
    output logic signed [gitr_pkg::COORD_W-1:0] about_y,
    output logic [1:0]                          status,
    output logic                                last
);
    import gitr_pkg::*;

    // configuration
    logic [15:0] grid_size_reg;
    logic [2:0]  view_radius_reg;

    // request latch
    state_t                    state_reg, state_next;
    logic [1:0]                func_reg, func_next;
    logic [ID_W-1:0]           id_reg, id_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]                st_reg, st_next;

    // old entry of the acted-on slot, taken when the divide finishes
    slot_entry_t               old_reg, old_next;
    logic                      same_reg, same_next;

    // slot valid bits and neighbor sets
    logic [SLOTS-1:0]          valid_reg, valid_next;
    logic [SLOTS-1:0]          bef_reg, bef_next, aft_reg, aft_next;

    // scan counters; read pipeline tag follows the memory latency
    logic [ID_W-1:0]           cnt_reg, cnt_next;
    logic                      issue_reg, issue_next;
    logic                      rvld_reg, rvld_next;
    logic [ID_W-1:0]           ridx_reg, ridx_next;
    logic [1:0]                pass_reg, pass_next;

    // memory and divider hookup
    logic                      mem_we, mem_re;
    logic [ID_W-1:0]           mem_raddr;
    slot_entry_t               mem_wdata, mem_rdata;
    logic                      div_go, div_done;
    logic signed [COORD_W-1:0] qx, qy;

    // result register
    logic                      emit;
    logic [ID_W-1:0]           e_target, e_about;
    logic [2:0]                e_kind;
    logic signed [COORD_W-1:0] e_x, e_y;
    logic [1:0]                e_status;
    logic                      e_last;

    logic                      nb_bef, nb_aft, other;
    logic [SLOTS-1:0]          pass_set;

    gitr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .divisor (grid_size_reg),
        .nx      (px_reg),
        .ny      (py_reg),
        .done    (div_done),
        .qx      (qx),
        .qy      (qy)
    );

    gitr_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (id_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mem_wdata = '{px: px_reg, py: py_reg, cx: cx_reg, cy: cy_reg};

    // neighbor test on the slot coming back from memory; add has no "before",
    // remove has no "after", a move to the same spot has neither
    assign other  = rvld_reg && (ridx_reg != id_reg) && valid_reg[ridx_reg];
    assign nb_bef = other && (func_reg != FUNC_ADD) && !same_reg
                    && axis_near(mem_rdata.cx, old_reg.cx, view_radius_reg)
                    && axis_near(mem_rdata.cy, old_reg.cy, view_radius_reg);
    assign nb_aft = other && (func_reg == FUNC_ADD || (func_reg == FUNC_MOVE && !same_reg))
                    && axis_near(mem_rdata.cx, cx_reg, view_radius_reg)
                    && axis_near(mem_rdata.cy, cy_reg, view_radius_reg);

    always_comb
    begin
        unique case (pass_reg)
            2'd0:    pass_set = bef_reg & aft_reg;
            2'd1:    pass_set = bef_reg & ~aft_reg;
            default: pass_set = aft_reg & ~bef_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        id_next    = id_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        st_next    = st_reg;
        old_next   = old_reg;
        same_next  = same_reg;
        valid_next = valid_reg;
        bef_next   = bef_reg;
        aft_next   = aft_reg;
        cnt_next   = cnt_reg;
        issue_next = issue_reg;
        rvld_next  = 1'b0;
        ridx_next  = cnt_reg;
        pass_next  = pass_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = cnt_reg;
        div_go     = 1'b0;
        emit       = 1'b0;
        e_target   = id_reg;
        e_about    = id_reg;
        e_kind     = KIND_STATUS;
        e_x        = '0;
        e_y        = '0;
        e_status   = ST_OK;
        e_last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    id_next    = entity_id;
                    px_next    = pos_x;
                    py_next    = pos_y;
                    st_next    = ST_OK;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (func_reg == FUNC_ADD && valid_reg[id_reg])
                begin
                    st_next    = ST_PRESENT;
                    state_next = S_STATUS;
                end
                else if (func_reg != FUNC_ADD && !(func_reg inside {FUNC_REMOVE, FUNC_MOVE}
                         && valid_reg[id_reg]))
                begin
                    st_next    = ST_ABSENT;
                    state_next = S_STATUS;
                end
                else
                begin
                    div_go     = 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = id_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cx_next    = qx;
                    cy_next    = qy;
                    old_next   = mem_rdata;
                    same_next  = (func_reg == FUNC_MOVE) && (mem_rdata.px == px_reg)
                                 && (mem_rdata.py == py_reg);
                    bef_next   = '0;
                    aft_next   = '0;
                    cnt_next   = '0;
                    issue_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                mem_re    = issue_reg;
                rvld_next = issue_reg;
                if (issue_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ID_W'(SLOTS-1))
                        issue_next = 1'b0;
                end
                if (nb_bef)
                    bef_next[ridx_reg] = 1'b1;
                if (nb_aft)
                    aft_next[ridx_reg] = 1'b1;
                if (rvld_reg && ridx_reg == ID_W'(SLOTS-1))
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (func_reg == FUNC_REMOVE)
                    valid_next[id_reg] = 1'b0;
                else
                begin
                    valid_next[id_reg] = 1'b1;
                    mem_we = !same_reg;
                end
                cnt_next   = '0;
                pass_next  = 2'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // one slot per cycle: move, then leave, then enter notices
                emit     = pass_set[cnt_reg];
                e_target = cnt_reg;
                unique case (pass_reg)
                    2'd0:    e_kind = KIND_MOVE;
                    2'd1:    e_kind = KIND_LEAVE;
                    default: e_kind = KIND_ENTER;
                endcase
                if (pass_reg != 2'd1)
                begin
                    e_x = px_reg;
                    e_y = py_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ID_W'(SLOTS-1))
                begin
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg == 2'd2)
                    begin
                        issue_next = 1'b1;
                        state_next = S_INVIEW;
                    end
                end
            end
            S_INVIEW:
            begin
                mem_re    = issue_reg;
                rvld_next = issue_reg;
                if (issue_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ID_W'(SLOTS-1))
                        issue_next = 1'b0;
                end
                emit    = rvld_reg && aft_reg[ridx_reg] && !bef_reg[ridx_reg];
                e_kind  = KIND_INVIEW;
                e_about = ridx_reg;
                e_x     = mem_rdata.px;
                e_y     = mem_rdata.py;
                if (rvld_reg && ridx_reg == ID_W'(SLOTS-1))
                    state_next = S_STATUS;
            end
            S_STATUS:
            begin
                emit       = 1'b1;
                e_status   = st_reg;
                e_last     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            grid_size_reg   <= 16'd64;
            view_radius_reg <= 3'd1;
            issue_reg       <= 1'b0;
            rvld_reg        <= 1'b0;
            cnt_reg         <= '0;
            pass_reg        <= '0;
            strobe          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            issue_reg <= issue_next;
            rvld_reg  <= rvld_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            strobe    <= emit;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_GRID_SIZE:   grid_size_reg   <= wr_data;
                    REG_VIEW_RADIUS: view_radius_reg <= wr_data[2:0];
                    default:         grid_size_reg   <= grid_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        id_reg    <= id_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        st_reg    <= st_next;
        old_reg   <= old_next;
        same_reg  <= same_next;
        bef_reg   <= bef_next;
        aft_reg   <= aft_next;
        ridx_reg  <= ridx_next;
        target_id <= e_target;
        kind      <= e_kind;
        about_id  <= e_about;
        about_x   <= e_x;
        about_y   <= e_y;
        status    <= e_status;
        last      <= e_last;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/gitr_checker.sv @@
module gitr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [2:0] kind,
    input logic       last
);
    import gitr_pkg::*;

    // request accepted raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // status item closes the request
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("busy still high on final status");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_STATUS) |-> last)
        else $error("status item without last");

    a_notice_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("notice outside a request");

endmodule

bind grid_interest_tracker gitr_checker u_gitr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .kind   (kind),
    .last   (last)
);

@@ tb/grid_interest_tracker_tb.sv @@
`default_nettype none

// Self-checking bench for the grid interest tracker.
// Requests go in over start/busy; every result strobe is compared against a
// behavioral copy of the slot table kept here. Inputs change on the rising
// edge, while busy and the result ports are sampled on the falling edge so
// nothing depends on event ordering within a timestep.
module grid_interest_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gitr_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         N_SLOTS     = 32;

    typedef struct {
        logic [4:0]         target;
        logic [2:0]         kind;
        logic [4:0]         about;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [1:0]         st;
        logic               last;
    } notice_t;

    // directed row; has_st marks a status value read straight off the spec
    typedef struct {
        logic [1:0]  f;
        logic [4:0]  id;
        int          x;
        int          y;
        bit          has_st;
        logic [1:0]  st;
    } req_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         func = '0;
    logic [4:0]         entity_id = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic               wr_en = 1'b0;
    logic               wr_index = 1'b0;
    logic [15:0]        wr_data = '0;
    logic               strobe;
    logic [4:0]         target_id;
    logic [2:0]         kind;
    logic [4:0]         about_id;
    logic signed [15:0] about_x;
    logic signed [15:0] about_y;
    logic [1:0]         status;
    logic               last;

    grid_interest_tracker dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .entity_id(entity_id), .pos_x(pos_x), .pos_y(pos_y),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .strobe(strobe), .target_id(target_id), .kind(kind),
        .about_id(about_id), .about_x(about_x), .about_y(about_y),
        .status(status), .last(last)
    );

    always #10 clk = ~clk;

    // shadow of the block's table and registers
    int  cfg_grid = 64;
    int  cfg_radius = 1;
    bit  occupied [N_SLOTS];
    int  at_x [N_SLOTS];
    int  at_y [N_SLOTS];
    int  cell_x [N_SLOTS];
    int  cell_y [N_SLOTS];

    notice_t pending_notices[$];
    int      errors = 0;
    int      notices_checked = 0;
    int      requests_sent = 0;
    int      notices_max = 0;

    function automatic int cell_of(int p);
        int g;
        begin
            g = (cfg_grid == 0) ? 1 : cfg_grid;
            cell_of = p / g;    // truncates toward zero
        end
    endfunction

    function automatic logic [31:0] in_view_of(int id);
        logic [31:0] m;
        int dx;
        int dy;
        begin
            m = '0;
            for (int s = 0; s < N_SLOTS; s++)
            begin
                dx = cell_x[s] - cell_x[id];
                dy = cell_y[s] - cell_y[id];
                if (s != id && occupied[s] && (dx < 0 ? -dx : dx) <= cfg_radius
                    && (dy < 0 ? -dy : dy) <= cfg_radius)
                    m[s] = 1'b1;
            end
            in_view_of = m;
        end
    endfunction

    task automatic push_notice(int tgt, logic [2:0] k, int ab, int x, int y,
                               logic [1:0] st, logic lst);
        notice_t n;
        begin
            n.target = tgt[4:0];
            n.kind   = k;
            n.about  = ab[4:0];
            n.ax     = x[15:0];
            n.ay     = y[15:0];
            n.st     = st;
            n.last   = lst;
            pending_notices.push_back(n);
        end
    endtask

    // one notice per member of the set, ascending slot order
    task automatic push_group(logic [31:0] set, logic [2:0] k, int id, int x, int y);
        begin
            for (int s = 0; s < N_SLOTS; s++)
                if (set[s])
                    push_notice(s, k, id, x, y, ST_OK, 1'b0);
        end
    endtask

    task automatic push_inview(logic [31:0] set, int id);
        begin
            for (int s = 0; s < N_SLOTS; s++)
                if (set[s])
                    push_notice(id, KIND_INVIEW, s, at_x[s], at_y[s], ST_OK, 1'b0);
        end
    endtask

    // apply one request to the shadow table and queue what it should emit
    task automatic predict_request(logic [1:0] f, int id, int x, int y,
                                   bit has_st, logic [1:0] typed_st);
        logic [1:0]  st;
        logic [31:0] was;
        logic [31:0] now;
        int          before_cnt;
        begin
            // the port carries 16 bits; wrap the same way
            x = $signed(x[15:0]);
            y = $signed(y[15:0]);
            st = ST_OK;
            before_cnt = pending_notices.size();
            if (f == FUNC_UNUSED)
                st = ST_ABSENT;
            else if (f == FUNC_ADD)
            begin
                if (occupied[id])
                    st = ST_PRESENT;
                else
                begin
                    occupied[id] = 1'b1;
                    at_x[id] = x;
                    at_y[id] = y;
                    cell_x[id] = cell_of(x);
                    cell_y[id] = cell_of(y);
                    now = in_view_of(id);
                    push_group(now, KIND_ENTER, id, x, y);
                    push_inview(now, id);
                end
            end
            else if (f == FUNC_REMOVE)
            begin
                if (!occupied[id])
                    st = ST_ABSENT;
                else
                begin
                    was = in_view_of(id);
                    occupied[id] = 1'b0;
                    push_group(was, KIND_LEAVE, id, 0, 0);
                end
            end
            else
            begin
                if (!occupied[id])
                    st = ST_ABSENT;
                else if (at_x[id] != x || at_y[id] != y)
                begin
                    was = in_view_of(id);
                    at_x[id] = x;
                    at_y[id] = y;
                    cell_x[id] = cell_of(x);
                    cell_y[id] = cell_of(y);
                    now = in_view_of(id);
                    push_group(was & now, KIND_MOVE, id, x, y);
                    push_group(was & ~now, KIND_LEAVE, id, 0, 0);
                    push_group(now & ~was, KIND_ENTER, id, x, y);
                    push_inview(now & ~was, id);
                end
            end
            if (has_st && typed_st != st)
                $display("%0t: note: typed status %0d differs from tracked status %0d",
                         $time, typed_st, st);
            push_notice(id, KIND_STATUS, id, 0, 0, has_st ? typed_st : st, 1'b1);
            if (pending_notices.size() - before_cnt > notices_max)
                notices_max = pending_notices.size() - before_cnt;
        end
    endtask

    // result checker: strobe lasts one cycle, so sample mid-cycle
    always @(negedge clk)
    begin
        notice_t e;
        if (rst_n && strobe)
        begin
            if (pending_notices.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result tgt=%0d kind=%0d about=%0d",
                         $time, target_id, kind, about_id);
            end
            else
            begin
                e = pending_notices.pop_front();
                notices_checked++;
                if (target_id !== e.target || kind !== e.kind || about_id !== e.about
                    || about_x !== e.ax || about_y !== e.ay || status !== e.st
                    || last !== e.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected tgt=%0d kind=%0d about=%0d x=%0d y=%0d st=%0d last=%0d",
                             $time, e.target, e.kind, e.about, e.ax, e.ay, e.st, e.last);
                    $display("%0t:          actual   tgt=%0d kind=%0d about=%0d x=%0d y=%0d st=%0d last=%0d",
                             $time, target_id, kind, about_id, about_x, about_y, status, last);
                end
            end
        end
    end

    // present a request; returns at the edge that transfers it, start still high
    task automatic send_request(logic [1:0] f, int id, int x, int y,
                                bit has_st, logic [1:0] typed_st);
        begin
            start     <= 1'b1;
            func      <= f;
            entity_id <= id[4:0];
            pos_x     <= x[15:0];
            pos_y     <= y[15:0];
            forever
            begin
                @(negedge clk);
                if (!busy)
                    break;
            end
            predict_request(f, id, x, y, has_st, typed_st);
            requests_sent++;
            @(posedge clk);
        end
    endtask

    task automatic idle_cycles(int n);
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off until every queued notice is out and the block is idle
    task automatic drain;
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_notices.size() != 0 || busy)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic idx, int value);
        begin
            wr_en    <= 1'b1;
            wr_index <= idx;
            wr_data  <= value[15:0];
            @(posedge clk);
            wr_en    <= 1'b0;
            if (idx == REG_GRID_SIZE)
                cfg_grid = value & 16'hFFFF;
            else
                cfg_radius = value & 7;
            @(posedge clk);
        end
    endtask

    // position near the populated area, now and then anywhere
    function automatic int pick_coord(int span);
        begin
            if ($urandom_range(0, 9) == 0)
                pick_coord = $signed(16'($urandom));
            else
                pick_coord = $urandom_range(0, 2 * span) - span;
        end
    endfunction

    req_row_t directed [] = '{
        '{FUNC_REMOVE, 5'd0,  0,      0,      1'b1, ST_ABSENT},
        '{FUNC_MOVE,   5'd0,  5,      5,      1'b1, ST_ABSENT},
        '{FUNC_UNUSED, 5'd7,  1,      1,      1'b1, ST_ABSENT},
        '{FUNC_ADD,    5'd0,  0,      0,      1'b1, ST_OK},
        '{FUNC_ADD,    5'd0,  9,      9,      1'b1, ST_PRESENT},
        '{FUNC_ADD,    5'd1,  63,     63,     1'b0, ST_OK},
        '{FUNC_ADD,    5'd31, -32768, -32768, 1'b0, ST_OK},
        '{FUNC_ADD,    5'd2,  32767,  32767,  1'b0, ST_OK},
        '{FUNC_ADD,    5'd3,  -64,    0,      1'b0, ST_OK},
        '{FUNC_ADD,    5'd4,  -63,    -127,   1'b0, ST_OK},
        '{FUNC_ADD,    5'd5,  100,    -70,    1'b0, ST_OK},
        '{FUNC_MOVE,   5'd1,  63,     63,     1'b1, ST_OK},
        '{FUNC_MOVE,   5'd1,  10,     20,     1'b0, ST_OK},
        '{FUNC_MOVE,   5'd1,  1000,   1000,   1'b0, ST_OK},
        '{FUNC_MOVE,   5'd1,  -1,     1,      1'b0, ST_OK},
        '{FUNC_MOVE,   5'd3,  -200,   0,      1'b0, ST_OK},
        '{FUNC_MOVE,   5'd31, 32767,  -32768, 1'b0, ST_OK},
        '{FUNC_ADD,    5'd6,  32704,  -32704, 1'b0, ST_OK},
        '{FUNC_REMOVE, 5'd0,  0,      0,      1'b0, ST_OK},
        '{FUNC_REMOVE, 5'd0,  0,      0,      1'b1, ST_ABSENT},
        '{FUNC_REMOVE, 5'd31, -1,     -1,     1'b0, ST_OK},
        '{FUNC_UNUSED, 5'd31, -1,     -1,     1'b1, ST_ABSENT}
    };

    // register settings per random phase; extremes included, grid 0 acts as 1
    int phase_grid   [] = '{64, 1, 65535, 0, 17, 300};
    int phase_radius [] = '{1, 0, 7, 2, 3, 7};

    initial
    begin
        int id;
        int span;
        int r;
        logic [1:0] f;
        bit calm;
        for (int s = 0; s < N_SLOTS; s++)
            occupied[s] = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings
        foreach (directed[i])
        begin
            send_request(directed[i].f, directed[i].id, directed[i].x, directed[i].y,
                         directed[i].has_st, directed[i].st);
            if ($urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 8));
        end

        for (int p = 0; p < phase_grid.size(); p++)
        begin
            drain();
            write_reg(REG_GRID_SIZE, phase_grid[p]);
            write_reg(REG_VIEW_RADIUS, phase_radius[p]);
            span = ((phase_grid[p] == 0 ? 1 : phase_grid[p]) * 3);
            if (span > 32767)
                span = 32767;
            calm = (p == phase_grid.size() - 1);   // final phase: no gaps
            for (int k = 0; k < 68; k++)
            begin
                id = $urandom_range(0, N_SLOTS - 1);
                r = $urandom_range(0, 99);
                if (r < 8)
                    f = 2'($urandom);                       // noise, any code
                else if (!occupied[id])
                    f = FUNC_ADD;
                else if (r < 30)
                    f = FUNC_REMOVE;
                else
                    f = FUNC_MOVE;
                if (f == FUNC_MOVE && $urandom_range(0, 9) == 0)
                    send_request(f, id, at_x[id] + $urandom_range(0, 2) - 1,
                                 at_y[id], 1'b0, ST_OK);
                else
                    send_request(f, id, pick_coord(span), pick_coord(span), 1'b0, ST_OK);
                if (!calm && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 8));
                if (k == 30 && p == 1)
                    drain();        // sender holds off until all results are out
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d requests over %0d register settings, %0d notices checked",
                 requests_sent, phase_grid.size() + 1, notices_checked);
        $display("largest burst from one request: %0d notices", notices_max);
        if (errors == 0 && pending_notices.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d notices outstanding", pending_notices.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
